// ----- rtl/ptpm_pkg.sv -----
// Shared types and constants for the pulse train pattern matcher.
// No dependencies; imported by every module of the block but ptpm_ram, and by the testbench.
package ptpm_pkg;

    localparam int DUR_W     = 25;   // signed duration, microseconds
    localparam int IDX_W     = 9;    // entry index field
    localparam int POS_OUT_W = 9;    // reported position field
    localparam int LEN_W     = 10;   // pattern_length register
    localparam int THR_W     = 24;   // leadin_threshold register
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 24;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_SAMPLE = 2'd1;
    localparam logic [1:0] MODE_REWIND = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEADIN_THRESH  = 1'd1;

    localparam logic [LEN_W-1:0] PATTERN_LENGTH_RST = 10'd2;
    localparam logic [THR_W-1:0] LEADIN_THRESH_RST  = 24'd10000;

    typedef struct packed {
        logic accept;   // input item taken this cycle
        logic commit;   // evaluated result moves to the output register
    } ctrl_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EVAL = 2'b10
    } ctrl_state_t;

endpackage

// ----- rtl/pulse_train_pattern_matcher.sv -----
// An accepted item reads its pattern entry through the registered store read, then the compare stage
// loads the result into the output register; a new item is taken only after the last one is committed,
// and a pending output register holds the compare stage and the input.
// Reset: rst_n clears position, handshake state and configuration registers to their defaults.
// The pattern store is not cleared; entries hold no defined value until written.
// Depends on ptpm_pkg, ptpm_ctrl, ptpm_dp and ptpm_ram.
module pulse_train_pattern_matcher
    import ptpm_pkg::*;
#(
    parameter int MAX_PATTERN = 512
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,   // [8:0] entry_index, [33:9] duration, rest zero
    input  logic [1:0]           s_tuser,   // [1:0] mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [8:0] position, rest zero
    output logic                 m_tuser,   // [0] matched
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    ctrl_cmd_t            cmd;
    logic [POS_OUT_W-1:0] position;
    logic                 unused_pad;

    assign unused_pad = ^s_tdata[39:IDX_W+DUR_W];

    ptpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ptpm_dp #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_mode     (s_tuser),
        .in_index    (s_tdata[IDX_W-1:0]),
        .in_duration (s_tdata[IDX_W+DUR_W-1:IDX_W]),
        .matched     (m_tuser),
        .position    (position)
    );

    assign m_tdata = {{(16-POS_OUT_W-1){1'b0}}, unused_pad & 1'b0, position};

endmodule

// ----- rtl/ptpm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptpm_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ptpm_ctrl.sv -----
// Controller: sequences accept, evaluate and output handoff.
// Depends on ptpm_pkg.
module ptpm_ctrl
    import ptpm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free   = !out_valid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign cmd.accept = s_tvalid && (state_reg == ST_IDLE);
    assign cmd.commit = (state_reg == ST_EVAL) && out_free;
    assign m_tvalid   = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                // hold the evaluated item until the output register frees up
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/ptpm_dp.sv -----
// Datapath: configuration, pattern store, match position and compare logic.
// Depends on ptpm_pkg and ptpm_ram.
module ptpm_dp
    import ptpm_pkg::*;
#(
    parameter int MAX_PATTERN = 512
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_cmd_t            cmd,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [1:0]           in_mode,
    input  logic [IDX_W-1:0]     in_index,
    input  logic [DUR_W-1:0]     in_duration,
    output logic                 matched,
    output logic [POS_OUT_W-1:0] position
);

    localparam int AW  = $clog2(MAX_PATTERN);
    localparam int LW  = $clog2(MAX_PATTERN + 1);
    localparam int CW  = ((LW > LEN_W) ? LW : LEN_W) + 1;
    localparam int XW  = ((AW > IDX_W) ? AW : IDX_W) + 1;
    localparam int XPW = (AW > POS_OUT_W) ? AW : POS_OUT_W;
    localparam logic [CW-1:0] MAX_LEN = CW'(MAX_PATTERN);

    logic [LEN_W-1:0]     length_reg;
    logic [THR_W-1:0]     thresh_reg;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [1:0]           mode_reg;
    logic [DUR_W-1:0]     sample_reg;
    logic                 matched_reg, matched_next;
    logic [POS_OUT_W-1:0] position_reg;

    logic [XW-1:0]    idx_ext;
    logic             ram_we;
    logic [DUR_W-1:0] entry;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= PATTERN_LENGTH_RST;
            thresh_reg <= LEADIN_THRESH_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_PATTERN_LENGTH)
            begin
                length_reg <= cfg_data[LEN_W-1:0];
            end
            else if (cfg_index == REG_LEADIN_THRESH)
            begin
                thresh_reg <= cfg_data[THR_W-1:0];
            end
        end
    end

    // drop writes beyond the store
    assign idx_ext = XW'(in_index);
    assign ram_we  = cmd.accept && (in_mode == MODE_WRITE)
                     && (idx_ext < XW'(MAX_PATTERN));

    ptpm_ram #(
        .WIDTH(DUR_W),
        .DEPTH(MAX_PATTERN)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_ext[AW-1:0]),
        .wdata (in_duration),
        .re    (cmd.accept),
        .raddr (pos_reg),
        .rdata (entry)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg   <= in_mode;
            sample_reg <= in_duration;
        end
    end

    // magnitudes and tolerance compare
    logic [DUR_W-1:0]   mag_a, mag_b;
    logic [DUR_W+2:0]   a5, a4, b5, b4;
    logic               in_tol;
    logic signed [DUR_W:0] lead_sum;
    logic               leadin;

    assign mag_a = sample_reg[DUR_W-1] ? (~sample_reg + 1'b1) : sample_reg;
    assign mag_b = entry[DUR_W-1] ? (~entry + 1'b1) : entry;
    assign a4 = {1'b0, mag_a, 2'b00};
    assign b4 = {1'b0, mag_b, 2'b00};
    assign a5 = a4 + (DUR_W+3)'(mag_a);
    assign b5 = b4 + (DUR_W+3)'(mag_b);
    assign in_tol = !(a5 < b4) && !(b5 < a4);

    // sample <= -threshold, i.e. sample + threshold <= 0
    assign lead_sum = $signed({sample_reg[DUR_W-1], sample_reg})
                      + $signed({{(DUR_W+1-THR_W){1'b0}}, thresh_reg});
    assign leadin   = lead_sum[DUR_W] || (lead_sum == '0);

    // effective length clamped to [2, MAX_PATTERN]
    logic [CW-1:0] len_ext, eff_len, last_pos;
    logic [AW:0]   pos_inc;
    logic          hit;

    assign len_ext = CW'(length_reg);

    always_comb
    begin
        priority if (len_ext < CW'(2))
        begin
            eff_len = CW'(2);
        end
        else if (len_ext > MAX_LEN)
        begin
            eff_len = MAX_LEN;
        end
        else
        begin
            eff_len = len_ext;
        end
    end

    assign last_pos = eff_len - CW'(1);
    assign pos_inc  = {1'b0, pos_reg} + (AW+1)'(1);
    assign hit      = ((pos_reg == '0) && leadin) || in_tol;

    always_comb
    begin
        pos_next     = pos_reg;
        matched_next = 1'b0;
        unique case (mode_reg)
            MODE_SAMPLE:
            begin
                if (hit)
                begin
                    if (CW'(pos_inc) >= last_pos)
                    begin
                        pos_next     = '0;
                        matched_next = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_inc[AW-1:0];
                    end
                end
                else
                begin
                    pos_next = leadin ? AW'(1) : '0;
                end
            end
            MODE_REWIND:
            begin
                pos_next = '0;
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
    end

    logic [XPW-1:0] pos_out_ext;
    assign pos_out_ext = XPW'(pos_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (cmd.commit)
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            matched_reg  <= matched_next;
            position_reg <= pos_out_ext[POS_OUT_W-1:0];
        end
    end

    assign matched  = matched_reg;
    assign position = position_reg;

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for pulse_train_pattern_matcher: random streams of pattern writes,
// samples and rewinds, with a built-in predictor of match position and match flag.
// Depends on ptpm_pkg and the RTL of the block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptpm_pkg::*;

    localparam int         MAX_PATTERN = 512;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam longint     DUR_MIN     = -16777216;
    localparam longint     DUR_MAX     = 16777215;

    typedef struct {
        logic [1:0]         mode;
        logic [8:0]         idx;
        logic signed [24:0] dur;
    } pulse_item_t;

    typedef struct {
        logic       matched;
        logic [8:0] position;
    } match_result_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [39:0]          s_tdata   = '0;   // [8:0] entry_index, [33:9] duration, rest zero
    logic [1:0]           s_tuser   = '0;   // [1:0] mode
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [15:0]          m_tdata;          // [8:0] position, rest zero
    logic                 m_tuser;          // [0] matched
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    pulse_train_pattern_matcher u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predictor state, updated as items and register writes are taken by the block
    logic signed [24:0] mirror_store [MAX_PATTERN];
    logic [8:0]         mirror_pos = '0;
    logic [LEN_W-1:0]   mirror_len = PATTERN_LENGTH_RST;
    logic [THR_W-1:0]   mirror_thr = LEADIN_THRESH_RST;

    pulse_item_t   pulse_items[$];
    match_result_t expected_matches[$];
    longint        gen_pattern [MAX_PATTERN];

    int items_queued = 0;
    int items_taken  = 0;
    int fail_count   = 0;
    int tx_idle      = 1;
    int rx_idle      = 1;
    int tx_gap       = 0;
    int rx_gap       = 0;
    int rx_hold      = 0;
    int hold_asked   = 0;
    int hold_given   = 0;
    bit in_taken     = 1'b0;
    bit out_taken    = 1'b0;

    function automatic int eff_len(logic [LEN_W-1:0] n);
        int v;
        v = n;
        if (v < 2)
            v = 2;
        if (v > MAX_PATTERN)
            v = MAX_PATTERN;
        return v;
    endfunction

    function automatic bit is_gap_start(longint s);
        return s <= -longint'(mirror_thr);
    endfunction

    function automatic match_result_t advance_matcher(pulse_item_t it);
        match_result_t r;
        longint        s;
        longint        e;
        longint        a;
        longint        b;
        int            nxt;
        r.matched = 1'b0;
        case (it.mode)
            MODE_WRITE:
                mirror_store[it.idx] = it.dur;
            MODE_SAMPLE:
            begin
                s = it.dur;
                e = mirror_store[mirror_pos];
                a = (s < 0) ? -s : s;
                b = (e < 0) ? -e : e;
                if ((mirror_pos == 0 && is_gap_start(s)) || !(5 * a < 4 * b || 5 * b < 4 * a))
                begin
                    nxt = int'(mirror_pos) + 1;
                    if (nxt >= eff_len(mirror_len) - 1)
                    begin
                        nxt = 0;
                        r.matched = 1'b1;
                    end
                end
                else
                    nxt = is_gap_start(s) ? 1 : 0;
                mirror_pos = nxt[8:0];
            end
            MODE_REWIND:
                mirror_pos = '0;
            default: ;
        endcase
        r.position = mirror_pos;
        return r;
    endfunction

    function automatic int draw_wait(int how);
        if (how == 0)
            return 0;
        if (how == 1)
            return $urandom_range(0, 14);
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
    endfunction

    // Sample near an entry: mostly inside the 4/5 to 5/4 window, its edges included, rarely just out
    function automatic longint near_dur(longint e, output bit off);
        longint b;
        longint lo;
        longint hi;
        longint a;
        b = (e < 0) ? -e : e;
        lo = (4 * b + 4) / 5;
        hi = (5 * b) / 4;
        off = 1'b0;
        case ($urandom_range(0, 63))
            0: a = lo;
            1: a = hi;
            2:
            begin
                a = hi + 1;
                off = 1'b1;
            end
            3:
            begin
                a = (lo > 0) ? lo - 1 : hi + 1;
                off = 1'b1;
            end
            default: a = lo + $urandom_range(0, int'(hi - lo));
        endcase
        if ((e < 0) != ($urandom_range(0, 15) == 0))
            a = -a;
        if (a < DUR_MIN)
            a = DUR_MIN;
        if (a > DUR_MAX)
            a = DUR_MAX;
        return a;
    endfunction

    function automatic longint leadin_dur(logic [THR_W-1:0] thr);
        longint v;
        v = -(longint'(thr) + $urandom_range(0, 2000));
        return (v < DUR_MIN) ? DUR_MIN : v;
    endfunction

    function automatic longint any_dur();
        return longint'($urandom_range(0, 33554431)) + DUR_MIN;
    endfunction

    task automatic push_item(input logic [1:0] mode, input int idx, input longint dur);
        pulse_item_t it;
        it.mode = mode;
        it.idx  = idx[8:0];
        it.dur  = dur[24:0];
        if (mode == MODE_WRITE)
            gen_pattern[it.idx] = it.dur;
        pulse_items.push_back(it);
        items_queued++;
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic wait_idle();
        while (items_taken != items_queued || expected_matches.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Load a fresh pattern, then mostly full pulse trains with random jitter, some broken
    // trains and some loose items
    task automatic run_phase(input logic [CFG_W-1:0] len_word, input logic [THR_W-1:0] thr,
                             input int budget);
        int     eff;
        int     n;
        int     k;
        int     kind;
        int     cut;
        bit     off;
        bit     broke;
        bit     at_zero;
        longint v;
        eff = eff_len(len_word[LEN_W-1:0]);
        set_reg(REG_PATTERN_LENGTH, len_word);
        set_reg(REG_LEADIN_THRESH, thr);
        n = 0;
        for (k = 0; k < eff; k++)
        begin
            v = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16777215)
                                            : $urandom_range(50, 5000);
            if (k == 0 || ((k % 2 == 0) != ($urandom_range(0, 15) == 0)))
                v = -v;
            push_item(MODE_WRITE, k, v);
            n++;
        end
        at_zero = 1'b0;
        while (n < budget)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 14)
            begin
                if (!at_zero || $urandom_range(0, 1))
                begin
                    push_item(MODE_REWIND, $urandom_range(0, 511), any_dur());
                    n++;
                end
                broke = 1'b0;
                for (k = 0; k < eff - 1; k++)
                begin
                    if (k == 0 && $urandom_range(0, 3) == 0)
                        v = leadin_dur(thr);
                    else
                    begin
                        v = near_dur(gen_pattern[k], off);
                        broke |= off;
                    end
                    push_item(MODE_SAMPLE, $urandom_range(0, 511), v);
                    n++;
                    if ($urandom_range(0, 24) == 0)
                        push_item(MODE_UNUSED, $urandom_range(0, 511), any_dur());
                end
                at_zero = !broke;
            end
            else if (kind < 17)
            begin
                push_item(MODE_REWIND, $urandom_range(0, 511), any_dur());
                cut = $urandom_range(0, eff - 2);
                for (k = 0; k < cut; k++)
                    push_item(MODE_SAMPLE, $urandom_range(0, 511), near_dur(gen_pattern[k], off));
                v = $urandom_range(0, 1) ? leadin_dur(thr) : any_dur();
                push_item(MODE_SAMPLE, $urandom_range(0, 511), v);
                n += cut + 2;
                at_zero = 1'b0;
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    kind = $urandom_range(0, 3);
                    if (kind == 0)
                        push_item(MODE_WRITE, $urandom_range(0, 511), any_dur());
                    else if (kind == 1)
                        push_item(MODE_SAMPLE, $urandom_range(0, 511), any_dur());
                    else if (kind == 2)
                        push_item(MODE_REWIND, $urandom_range(0, 511), any_dur());
                    else
                        push_item(MODE_UNUSED, $urandom_range(0, 511), any_dur());
                    if (kind != 3)
                        n++;
                end
                at_zero = 1'b0;
            end
        end
        wait_idle();
    endtask

    // Sender: hold an offered item until taken, then idle for the drawn gap
    always @(negedge clk)
    begin
        pulse_item_t it;
        if (!s_tvalid || in_taken)
        begin
            in_taken = 1'b0;
            if (tx_gap > 0)
            begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pulse_items.size() > 0)
            begin
                it = pulse_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= it.mode;
                s_tdata  <= {6'd0, it.dur, it.idx};
                tx_gap = draw_wait(tx_idle);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls per result, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_asked != hold_given)
        begin
            hold_given = hold_asked;
            rx_hold = 250;
        end
        if (out_taken)
        begin
            out_taken = 1'b0;
            rx_gap = draw_wait(rx_idle);
        end
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_tready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        match_result_t want;
        pulse_item_t   seen;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                out_taken = 1'b1;
                if (expected_matches.size() == 0)
                begin
                    $error("result with no item pending: position %0d matched %0d",
                           m_tdata[8:0], m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = expected_matches.pop_front();
                    if (m_tuser !== want.matched)
                    begin
                        $error("matched: expected %0d, got %0d", want.matched, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[8:0] !== want.position)
                    begin
                        $error("position: expected %0d, got %0d", want.position, m_tdata[8:0]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                in_taken = 1'b1;
                items_taken++;
                seen.mode = s_tuser;
                seen.idx  = s_tdata[8:0];
                seen.dur  = s_tdata[33:9];
                expected_matches.push_back(advance_matcher(seen));
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_PATTERN_LENGTH)
                    mirror_len = cfg_data[LEN_W-1:0];
                else if (cfg_index == REG_LEADIN_THRESH)
                    mirror_thr = cfg_data[THR_W-1:0];
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Extremes at reset settings: saturated durations, unused mode, lead-in at start
        push_item(MODE_WRITE, 0, DUR_MIN);
        push_item(MODE_WRITE, 511, DUR_MAX);
        push_item(MODE_UNUSED, 511, -1);
        push_item(MODE_SAMPLE, 0, DUR_MIN);
        push_item(MODE_SAMPLE, 0, 0);
        push_item(MODE_SAMPLE, 0, DUR_MAX);
        push_item(MODE_REWIND, 0, 0);
        wait_idle();

        // Zero threshold, window edges, miss back to zero and miss onto a lead-in
        set_reg(REG_PATTERN_LENGTH, CFG_W'(4));
        set_reg(REG_LEADIN_THRESH, '0);
        push_item(MODE_WRITE, 1, 1000);
        push_item(MODE_WRITE, 2, -500);
        push_item(MODE_SAMPLE, 0, 0);
        push_item(MODE_SAMPLE, 0, 800);
        push_item(MODE_SAMPLE, 0, -625);
        push_item(MODE_SAMPLE, 0, -1);
        push_item(MODE_SAMPLE, 0, 799);
        push_item(MODE_SAMPLE, 0, -1);
        push_item(MODE_SAMPLE, 0, -5);
        push_item(MODE_SAMPLE, 0, 1000);
        wait_idle();

        // Shrink the pattern below the current position; zero length acts as two
        set_reg(REG_PATTERN_LENGTH, '0);
        push_item(MODE_SAMPLE, 0, -500);
        push_item(MODE_SAMPLE, 0, 1251);
        wait_idle();

        run_phase(CFG_W'(5), THR_W'(10000), 150);

        tx_idle = 0;
        rx_idle = 0;
        hold_asked++;
        run_phase(CFG_W'(9), '0, 200);

        tx_idle = 2;
        rx_idle = 2;
        run_phase(CFG_W'(1023), THR_W'($urandom_range(0, 20000)), 513);

        tx_idle = 1;
        rx_idle = 2;
        run_phase(CFG_W'(16), 24'hFFFFFF, 150);

        tx_idle = 2;
        rx_idle = 1;
        run_phase(24'hABC002, THR_W'($urandom()), 100);

        tx_idle = 1;
        rx_idle = 1;
        run_phase(CFG_W'($urandom_range(3, 30)), THR_W'($urandom_range(0, 5000)), 150);

        tx_idle = 0;
        rx_idle = 1;
        run_phase(CFG_W'(7), LEADIN_THRESH_RST, 150);

        if (expected_matches.size() != 0)
        begin
            $error("%0d results never arrived", expected_matches.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
